@@ rtl/core/owmu_pkg.sv @@
// Package for the 1-Wire master over UART: operation and phase codes, slot characters,
// register defaults and the state and result structs. Depends on nothing.
`default_nettype none

package owmu_pkg;

  typedef enum logic [2:0] {
    OP_RESET   = 3'd0,
    OP_WRITE   = 3'd1,
    OP_READ    = 3'd2,
    OP_ABORT   = 3'd3,
    OP_TX_DONE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RESET = 3'd1,
    PH_WRITE = 3'd2,
    PH_READ  = 3'd3,
    PH_FAIL  = 3'd4
  } phase_t;

  // Configuration register indexes.
  localparam logic REG_RESET_DIV = 1'b0;
  localparam logic REG_SLOT_DIV  = 1'b1;

  localparam logic [7:0]  CH_RESET = 8'hF0;
  localparam logic [7:0]  CH_ONE   = 8'hFF;
  localparam logic [7:0]  CH_ZERO  = 8'h00;
  localparam logic [3:0]  LAST_BIT = 4'd8;
  localparam logic [15:0] RESET_DIV_DEFAULT = 16'd5000;
  localparam logic [15:0] SLOT_DIV_DEFAULT  = 16'd417;

  typedef struct packed {
    phase_t     phase;
    logic       presence;
    logic [7:0] read_shift;
    logic [7:0] write_shift;
    logic [3:0] bit_count;
    logic       mismatch;
  } owmu_state_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_char;
    logic [15:0] baud_divisor;
    logic [2:0]  bus_state;
    logic        device_present;
    logic [7:0]  read_result;
  } owmu_result_t;

  function automatic logic [7:0] slot_char(input logic bit_val);
    return bit_val ? CH_ONE : CH_ZERO;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/owmu_in_if.sv @@
// Input channel of the 1-Wire master: commands and transmit-done words.
// Depends on nothing.
`default_nettype none

interface owmu_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_byte;
  logic       echo_valid;
  logic [7:0] echo_char;

  modport source(output valid, operation, write_byte, echo_valid, echo_char, input ready);
  modport sink(input valid, operation, write_byte, echo_valid, echo_char, output ready);
endinterface

`default_nettype wire

@@ rtl/core/owmu_out_if.sv @@
// Result channel of the 1-Wire master: one word per accepted input word.
// Depends on nothing.
`default_nettype none

interface owmu_out_if;
  logic        valid;
  logic        ready;
  logic        send_valid;
  logic [7:0]  send_char;
  logic [15:0] baud_divisor;
  logic [2:0]  bus_state;
  logic        device_present;
  logic [7:0]  read_result;

  modport source(output valid, send_valid, send_char, baud_divisor, bus_state,
                 device_present, read_result, input ready);
  modport sink(input valid, send_valid, send_char, baud_divisor, bus_state,
               device_present, read_result, output ready);
endinterface

`default_nettype wire

@@ rtl/core/one_wire_master_over_uart_unit.sv @@
// Top level of the 1-Wire master over UART; uses owmu_pkg, owmu_in_if, owmu_out_if, owmu_step.
// Each accepted input word has its result word in the output register in the next cycle.
// Throughput: one word per cycle; the input is ready whenever the output register is empty
// or is being taken in the same cycle, so the only limit is the single output register.
// Reset (synchronous, rst_n low): bus idle, presence and shift registers cleared, the output
// register empty, reset divisor 5000 and slot divisor 417.
`default_nettype none

module one_wire_master_over_uart_unit (
  input  logic             clk,
  input  logic             rst_n,
  owmu_in_if.sink          in_ch,
  owmu_out_if.source       out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import owmu_pkg::*;

  // Configuration registers. Writes land on the access phase of an APB transfer;
  // the register is chosen by address bit 2 (one 32-bit slot per register).
  logic [15:0] reset_div_r;
  logic [15:0] slot_div_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_div_r <= RESET_DIV_DEFAULT;
      slot_div_r  <= SLOT_DIV_DEFAULT;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RESET_DIV) begin
        reset_div_r <= pwdata[15:0];
      end else begin
        slot_div_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = {16'h0000, (paddr[2] == REG_SLOT_DIV) ? slot_div_r : reset_div_r};

  // Bus state and the output register. A word is taken whenever the output
  // register is free or drains in this cycle, so words may follow back to back.
  owmu_state_t  state_r;
  owmu_state_t  state_nxt;
  owmu_result_t res_r;
  owmu_result_t res_nxt;
  logic         out_valid_r;
  logic         in_take;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  owmu_step u_step (
    .cur_state  (state_r),
    .operation  (in_ch.operation),
    .write_byte (in_ch.write_byte),
    .echo_valid (in_ch.echo_valid),
    .echo_char  (in_ch.echo_char),
    .reset_div  (reset_div_r),
    .slot_div   (slot_div_r),
    .nxt_state  (state_nxt),
    .result     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_IDLE, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the result word needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.send_valid     = res_r.send_valid;
  assign out_ch.send_char      = res_r.send_char;
  assign out_ch.baud_divisor   = res_r.baud_divisor;
  assign out_ch.bus_state      = res_r.bus_state;
  assign out_ch.device_present = res_r.device_present;
  assign out_ch.read_result    = res_r.read_result;

endmodule

`default_nettype wire

@@ rtl/core/owmu_step.sv @@
// Combinational step of the 1-Wire master: next bus state and the result word.
// Depends on owmu_pkg.
`default_nettype none

module owmu_step (
  input  owmu_pkg::owmu_state_t  cur_state,
  input  logic [2:0]             operation,
  input  logic [7:0]             write_byte,
  input  logic                   echo_valid,
  input  logic [7:0]             echo_char,
  input  logic [15:0]            reset_div,
  input  logic [15:0]            slot_div,
  output owmu_pkg::owmu_state_t  nxt_state,
  output owmu_pkg::owmu_result_t result
);
  import owmu_pkg::*;

  logic       free_now;
  logic       write_miss;
  logic [7:0] wshift_next;

  assign free_now    = (cur_state.phase == PH_IDLE) || (cur_state.phase == PH_FAIL);
  assign write_miss  = cur_state.mismatch || (echo_char != slot_char(cur_state.write_shift[0]));
  assign wshift_next = {1'b0, cur_state.write_shift[7:1]};

  // Next state.
  always_comb begin
    nxt_state = cur_state;
    unique case (operation)
      OP_RESET: begin
        if (free_now) begin
          nxt_state.phase    = PH_RESET;
          nxt_state.presence = 1'b0;
        end
      end
      OP_WRITE: begin
        if (free_now) begin
          nxt_state.phase       = PH_WRITE;
          nxt_state.write_shift = write_byte;
          nxt_state.bit_count   = 4'd1;
          nxt_state.mismatch    = 1'b0;
        end
      end
      OP_READ: begin
        if (free_now) begin
          nxt_state.phase     = PH_READ;
          nxt_state.bit_count = 4'd1;
        end
      end
      OP_ABORT: begin
        nxt_state.phase    = PH_IDLE;
        nxt_state.presence = 1'b0;
      end
      OP_TX_DONE: begin
        if (!echo_valid) begin
          nxt_state.phase = PH_FAIL;
        end else begin
          unique case (cur_state.phase)
            PH_RESET: begin
              if (echo_char != CH_RESET) begin
                nxt_state.presence = 1'b1;
              end
              nxt_state.phase = PH_IDLE;
            end
            PH_WRITE: begin
              nxt_state.mismatch = write_miss;
              if (cur_state.bit_count >= LAST_BIT) begin
                nxt_state.phase = write_miss ? PH_FAIL : PH_IDLE;
              end else begin
                nxt_state.write_shift = wshift_next;
                nxt_state.bit_count   = cur_state.bit_count + 4'd1;
              end
            end
            PH_READ: begin
              // Bits arrive least significant first, so shift in from the top.
              nxt_state.read_shift = {(echo_char == CH_ONE), cur_state.read_shift[7:1]};
              if (cur_state.bit_count >= LAST_BIT) begin
                nxt_state.phase = PH_IDLE;
              end else begin
                nxt_state.bit_count = cur_state.bit_count + 4'd1;
              end
            end
            default: begin
              // Echoes while idle or failed are dropped.
            end
          endcase
        end
      end
      default: begin
        // Codes with no meaning leave the state alone.
      end
    endcase
  end

  // Result word.
  always_comb begin
    result = '0;
    unique case (operation)
      OP_RESET: begin
        if (free_now) begin
          result.send_valid = 1'b1;
          result.send_char  = CH_RESET;
        end
      end
      OP_WRITE: begin
        if (free_now) begin
          result.send_valid = 1'b1;
          result.send_char  = slot_char(write_byte[0]);
        end
      end
      OP_READ: begin
        if (free_now) begin
          result.send_valid = 1'b1;
          result.send_char  = CH_ONE;
        end
      end
      OP_TX_DONE: begin
        if (echo_valid && (cur_state.bit_count < LAST_BIT)) begin
          if (cur_state.phase == PH_WRITE) begin
            result.send_valid = 1'b1;
            result.send_char  = slot_char(wshift_next[0]);
          end else if (cur_state.phase == PH_READ) begin
            result.send_valid = 1'b1;
            result.send_char  = CH_ONE;
          end
        end
      end
      default: begin
        // Abort and unused codes send nothing.
      end
    endcase
    result.baud_divisor = ((nxt_state.phase == PH_WRITE) || (nxt_state.phase == PH_READ))
                          ? slot_div : reset_div;
    result.bus_state      = nxt_state.phase;
    result.device_present = nxt_state.presence;
    result.read_result    = (nxt_state.phase == PH_READ) ? 8'h00 : nxt_state.read_shift;
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for one_wire_master_over_uart_unit: directed and random command and
// echo words, result words predicted in the bench and compared field by field.
// Depends on owmu_pkg, owmu_in_if, owmu_out_if and the top level of the block.
module testbench;
  import owmu_pkg::*;

  // Operation codes that the block has no meaning for; they must be ignored.
  localparam logic [2:0] OP_UNDEFINED_LO = 3'd5;
  localparam logic [2:0] OP_UNDEFINED_HI = 3'd7;

  // Cycle limit for the whole run; it lies far beyond what a correct run needs.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int WORDS_PER_PHASE = 500;
  localparam int PRINT_CAP       = 60;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  owmu_in_if  in_ch();
  owmu_out_if out_ch();

  one_wire_master_over_uart_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench copy of the bus master state and of its two divisor registers. It is advanced
  // once for every command or event word at the clock edge where the block accepts it.
  phase_t      bus_phase;
  logic        presence;
  logic [7:0]  rd_shift;
  logic [7:0]  wr_shift;
  logic [3:0]  slot_count;
  logic        mismatch;
  logic [15:0] reset_div;
  logic [15:0] slot_div;

  // Result words still owed by the block, oldest first.
  owmu_result_t pending_responses[$];
  owmu_result_t head_word;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int words_sent         = 0;
  int results_seen       = 0;
  int mismatch_count     = 0;
  int cycle_count        = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Character that a bit slot carries: all ones for a one, all zeros for a zero.
  function automatic logic [7:0] bit_slot_char(input logic b);
    return b ? CH_ONE : CH_ZERO;
  endfunction

  // Advances the bench copy of the state by one word and returns the result word that the
  // block must give for it. Busy phases ignore new commands, abort always returns to idle,
  // and a transmit-done word without an echo drops the bus into fail from any phase.
  function automatic owmu_result_t next_bus_response(input logic [2:0] op,
                                                     input logic [7:0] wbyte,
                                                     input logic evalid,
                                                     input logic [7:0] echr);
    owmu_result_t r;
    logic         send;
    logic [7:0]   ch;
    logic         idle_or_failed;
    send = 1'b0;
    ch = CH_ZERO;
    idle_or_failed = (bus_phase == PH_IDLE) || (bus_phase == PH_FAIL);
    case (op)
      OP_RESET: if (idle_or_failed) begin
        bus_phase = PH_RESET;
        presence = 1'b0;
        send = 1'b1;
        ch = CH_RESET;
      end
      OP_WRITE: if (idle_or_failed) begin
        bus_phase = PH_WRITE;
        wr_shift = wbyte;
        slot_count = 4'd1;
        mismatch = 1'b0;
        send = 1'b1;
        ch = bit_slot_char(wbyte[0]);
      end
      OP_READ: if (idle_or_failed) begin
        // The first slot goes out with the command, so the count starts at one.
        bus_phase = PH_READ;
        slot_count = 4'd1;
        send = 1'b1;
        ch = CH_ONE;
      end
      OP_ABORT: begin
        bus_phase = PH_IDLE;
        presence = 1'b0;
      end
      OP_TX_DONE: begin
        if (!evalid) begin
          bus_phase = PH_FAIL;
        end else if (bus_phase == PH_RESET) begin
          // Anything other than our own reset character means a device pulled the bus low.
          if (echr != CH_RESET) presence = 1'b1;
          bus_phase = PH_IDLE;
        end else if (bus_phase == PH_WRITE) begin
          // A bad echo does not stop the write; it only turns the final state into fail.
          if (echr != bit_slot_char(wr_shift[0])) mismatch = 1'b1;
          if (slot_count >= LAST_BIT) begin
            bus_phase = mismatch ? PH_FAIL : PH_IDLE;
          end else begin
            wr_shift = wr_shift >> 1;
            send = 1'b1;
            ch = bit_slot_char(wr_shift[0]);
            slot_count = slot_count + 4'd1;
          end
        end else if (bus_phase == PH_READ) begin
          rd_shift = {echr == CH_ONE, rd_shift[7:1]};
          if (slot_count >= LAST_BIT) begin
            bus_phase = PH_IDLE;
          end else begin
            send = 1'b1;
            ch = CH_ONE;
            slot_count = slot_count + 4'd1;
          end
        end
      end
      default: ;
    endcase
    r.send_valid     = send;
    r.send_char      = ch;
    r.baud_divisor   = (bus_phase == PH_WRITE || bus_phase == PH_READ) ? slot_div : reset_div;
    r.bus_state      = bus_phase;
    r.device_present = presence;
    r.read_result    = (bus_phase == PH_READ) ? 8'h00 : rd_shift;
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string label, input int got, input int want);
    if (got != want) report_error($sformatf("%s: got 0x%0h, expected 0x%0h", label, got, want));
  endtask

  // Sends one word on the input channel. The task is entered and left at a falling edge.
  // Idle cycles, if any, come first; valid is raised only once the word is placed, so it
  // stays high from one word to the next when the sender does not idle.
  task automatic send_word(input logic [2:0] op, input logic [7:0] wbyte,
                           input logic evalid, input logic [7:0] echr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.operation  = op;
    in_ch.write_byte = wbyte;
    in_ch.echo_valid = evalid;
    in_ch.echo_char  = echr;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_responses.push_back(next_bus_response(op, wbyte, evalid, echr));
    words_sent++;
    @(negedge clk);
  endtask

  // Commands carry random echo fields and echoes a random write byte, so that the unused
  // fields of every word toggle as well.
  task automatic send_command(input logic [2:0] op, input logic [7:0] wbyte);
    send_word(op, wbyte, 1'($urandom), 8'($urandom));
  endtask

  task automatic send_echo(input logic [7:0] echr);
    send_word(OP_TX_DONE, 8'($urandom), 1'b1, echr);
  endtask

  task automatic send_missing_echo();
    send_word(OP_TX_DONE, 8'($urandom), 1'b0, 8'($urandom));
  endtask

  // Stops sending and waits until every result word has come back. Every word causes one
  // result, so once the queue is empty the block is idle; the extra wait is margin only.
  task automatic settle_bus();
    in_ch.valid = 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes one divisor register through a setup and an access cycle, then reads it back.
  task automatic write_register(input logic idx, input logic [15:0] value);
    logic [31:0] readback;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (idx == REG_RESET_DIV) reset_div = value;
    else slot_div = value;
    @(negedge clk);
    psel   = 1'b1;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    check_field($sformatf("register %0d readback", idx), readback[15:0], value);
  endtask

  // Reset pulses: an echo equal to the reset character means nobody answered, any other
  // echo is a presence pulse, and a lost echo puts the bus into fail.
  task automatic test_reset_pulse();
    send_command(OP_RESET, 8'($urandom));
    send_echo(CH_RESET);
    send_command(OP_RESET, 8'($urandom));
    send_echo(8'hE0);
    send_command(OP_RESET, 8'($urandom));
    send_missing_echo();
  endtask

  // A full write of 0xA5 starting from fail, with correct echoes. A read command issued
  // halfway through must be ignored because the bus is busy.
  task automatic test_write_byte();
    send_command(OP_WRITE, 8'hA5);
    for (int i = 0; i < 8; i++) begin
      if (i == 3) send_command(OP_READ, 8'($urandom));
      send_echo(bit_slot_char(wr_shift[0]));
    end
  endtask

  // A full read: all-ones echoes shift in ones, anything else shifts in zeros, and the
  // result stays zero until the eighth slot has come back.
  task automatic test_read_byte();
    logic [7:0] echoes [8];
    echoes = '{CH_ONE, CH_ZERO, CH_ONE, CH_ONE, 8'h5A, CH_ONE, CH_ZERO, CH_ONE};
    send_command(OP_READ, 8'($urandom));
    foreach (echoes[i]) send_echo(echoes[i]);
  endtask

  // Words that change nothing or only clear state: undefined operations, an echo while the
  // bus is idle and an abort that clears presence; then a lost echo puts the idle bus into fail.
  task automatic test_ignored_words();
    send_command(OP_UNDEFINED_LO, 8'hFF);
    send_command(OP_UNDEFINED_HI, 8'h00);
    send_echo(8'h3C);
    send_command(OP_ABORT, 8'($urandom));
    send_missing_echo();
  endtask

  // One phase of random traffic under one register setting and one idling pattern. Most of
  // it is complete reset, write and read transactions with random content, so that every
  // bit slot is reached; the rest is lost echoes, aborts, busy commands and plain noise.
  task automatic test_random_traffic(input logic [15:0] reset_div_value,
                                     input logic [15:0] slot_div_value,
                                     input int idle_pct, input int stall_pct);
    int         first_word;
    int         kind;
    int         r;
    logic [7:0] wbyte;
    settle_bus();
    write_register(REG_RESET_DIV, reset_div_value);
    write_register(REG_SLOT_DIV, slot_div_value);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    first_word = words_sent;
    while (words_sent - first_word < WORDS_PER_PHASE) begin
      kind = $urandom_range(99);
      // A transaction can only start from idle or fail, so a busy bus is aborted first.
      if (kind < 80 && bus_phase != PH_IDLE && bus_phase != PH_FAIL)
        send_command(OP_ABORT, 8'($urandom));
      if (kind < 20) begin
        send_command(OP_RESET, 8'($urandom));
        r = $urandom_range(99);
        if (r < 5) send_missing_echo();
        else send_echo((r < 50) ? CH_RESET : 8'($urandom));
      end else if (kind < 50) begin
        r = $urandom_range(9);
        wbyte = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        send_command(OP_WRITE, wbyte);
        for (int i = 0; i < 8; i++) begin
          r = $urandom_range(99);
          if (r < 3) begin
            send_missing_echo();
            break;
          end
          if (r < 5) begin
            send_command(OP_ABORT, 8'($urandom));
            break;
          end
          if (r < 10) send_command(3'($urandom_range(OP_READ)), 8'($urandom));
          send_echo((r < 18) ? 8'($urandom) : bit_slot_char(wr_shift[0]));
        end
      end else if (kind < 80) begin
        send_command(OP_READ, 8'($urandom));
        for (int i = 0; i < 8; i++) begin
          r = $urandom_range(99);
          if (r < 3) begin
            send_missing_echo();
            break;
          end
          if (r < 5) begin
            send_command(OP_ABORT, 8'($urandom));
            break;
          end
          if (r < 10) send_command(3'($urandom_range(OP_READ)), 8'($urandom));
          r = $urandom_range(3);
          send_echo((r < 2) ? CH_ONE : (r == 2) ? CH_ZERO : 8'($urandom));
        end
      end else begin
        send_word(3'($urandom_range(7)), 8'($urandom), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  // The receiver decides at every falling edge whether it takes a word in the next cycle.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every result word taken by the receiver is matched with the oldest prediction. Values
  // are sampled at the rising edge, before the block updates its registers.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_responses.size() == 0) begin
        report_error($sformatf("result word %0d with no word waiting for it", results_seen));
      end else begin
        head_word = pending_responses.pop_front();
        check_field($sformatf("word %0d send_valid", results_seen),
                    out_ch.send_valid, head_word.send_valid);
        check_field($sformatf("word %0d send_char", results_seen),
                    out_ch.send_char, head_word.send_char);
        check_field($sformatf("word %0d baud_divisor", results_seen),
                    out_ch.baud_divisor, head_word.baud_divisor);
        check_field($sformatf("word %0d bus_state", results_seen),
                    out_ch.bus_state, head_word.bus_state);
        check_field($sformatf("word %0d device_present", results_seen),
                    out_ch.device_present, head_word.device_present);
        check_field($sformatf("word %0d read_result", results_seen),
                    out_ch.read_result, head_word.read_result);
      end
      results_seen++;
    end
  end

  // A hung handshake ends the run here instead of running forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout with %0d result words outstanding", pending_responses.size());
      $display("one_wire_master_over_uart_unit verification failed");
      $finish;
    end
  end

  initial begin
    // Every input is known from time zero; the block is held in reset before the tests start.
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_ABORT;
    in_ch.write_byte = 8'h00;
    in_ch.echo_valid = 1'b0;
    in_ch.echo_char  = 8'h00;
    out_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    bus_phase        = PH_IDLE;
    presence         = 1'b0;
    rd_shift         = 8'h00;
    wr_shift         = 8'h00;
    slot_count       = 4'd0;
    mismatch         = 1'b0;
    reset_div        = RESET_DIV_DEFAULT;
    slot_div         = SLOT_DIV_DEFAULT;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // The directed part runs on the reset values of the divisors, which checks them too.
    test_reset_pulse();
    test_write_byte();
    test_read_byte();
    test_ignored_words();

    // Random phases: divisor extremes, zero divisors and a random pair, each under its
    // own idling pattern (none, sender gaps, receiver stalls, both).
    test_random_traffic(16'hFFFF, 16'h0001, 0, 0);
    test_random_traffic(16'h0001, 16'hFFFF, 65, 0);
    test_random_traffic(16'h0000, 16'h0000, 0, 65);
    test_random_traffic(16'($urandom), 16'($urandom), 17, 17);

    // Let every result drain, then keep the clock running so that stray words can show up.
    settle_bus();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("one_wire_master_over_uart_unit verification clean");
    end else begin
      $display("one_wire_master_over_uart_unit verification failed");
    end
    $finish;
  end

endmodule
